@@ rtl/core/vsa_pkg.sv @@
// Shared types, codes and constants of the voice slot allocator.
`timescale 1ns / 1ps
package vsa_pkg;

  localparam int unsigned VOICES_DEF   = 32;
  localparam int unsigned GEN_BITS_DEF = 8;
  localparam int unsigned SCORE_W      = 25;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;

  localparam logic [1:0] CFG_LISTENER_X = 2'd0;
  localparam logic [1:0] CFG_LISTENER_Y = 2'd1;
  localparam logic [1:0] CFG_LISTENER_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_STOLE    = 3'd1,
    ST_REJECT   = 3'd2,
    ST_RELEASED = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_VALID    = 3'd5,
    ST_INVALID  = 3'd6
  } status_e;

  typedef struct packed {
    logic               spatial;
    logic [7:0]         prio;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic [15:0]        reach;
  } voice_t;

  typedef struct packed {
    logic   active;
    logic   persistent;
    voice_t voice;
  } entry_t;

endpackage

@@ rtl/core/vsa_cell.sv @@
// One slot of the voice ring: holds an entry and its generation.
`timescale 1ns / 1ps
module vsa_cell #(
  parameter int unsigned GEN_BITS = vsa_pkg::GEN_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  vsa_pkg::entry_t     ent_i,
  input  logic [GEN_BITS-1:0] gen_i,
  output vsa_pkg::entry_t     ent_o,
  output logic [GEN_BITS-1:0] gen_o
);

  vsa_pkg::entry_t     ent_q;
  logic [GEN_BITS-1:0] gen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      gen_q <= GEN_BITS'(1);
    end else if (shift_i) begin
      ent_q <= ent_i;
      gen_q <= gen_i;
    end
  end

  assign ent_o = ent_q;
  assign gen_o = gen_q;

endmodule

@@ rtl/core/vsa_score.sv @@
// Iterative voice score unit: squares, integer root, restoring divide.
`timescale 1ns / 1ps
module vsa_score (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  vsa_pkg::voice_t               voice_i,
  input  logic signed [15:0]            lis_x_i,
  input  logic signed [15:0]            lis_y_i,
  input  logic signed [15:0]            lis_z_i,
  output logic                          done_o,
  output logic [vsa_pkg::SCORE_W-1:0]   score_o
);

  typedef enum logic [4:0] {
    SC_IDLE = 5'b00001,
    SC_SQ   = 5'b00010,
    SC_ROOT = 5'b00100,
    SC_DIV  = 5'b01000,
    SC_FIN  = 5'b10000
  } sc_state_e;

  sc_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  vsa_pkg::voice_t v_q, v_d;
  logic [33:0] acc_q, acc_d;
  logic [33:0] rad_q, rad_d;
  logic [19:0] rem_q, rem_d;
  logic [16:0] root_q, root_d;
  logic [15:0] rdiv_q, rdiv_d;
  logic [15:0] quo_q, quo_d;
  logic [16:0] n_q, n_d;
  logic [vsa_pkg::SCORE_W-1:0] score_q, score_d;

  logic signed [15:0] a, b;
  logic signed [16:0] diff, neg;
  logic [15:0] mag;
  logic [31:0] sq;
  logic [15:0] m_eff;
  logic [19:0] rem_sh, trial;
  logic        ge_r;
  logic [16:0] r2, r2m;
  logic        ge_d;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd1: begin a = v_q.py; b = lis_y_i; end
      2'd2: begin a = v_q.pz; b = lis_z_i; end
      default: begin a = v_q.px; b = lis_x_i; end
    endcase
    diff   = {a[15], a} - {b[15], b};
    neg    = -diff;
    mag    = diff[16] ? neg[15:0] : diff[15:0];
    sq     = mag * mag;
    m_eff  = (v_q.reach == 16'd0) ? 16'd1 : v_q.reach;
    rem_sh = {rem_q[17:0], rad_q[33:32]};
    trial  = {1'b0, root_q, 2'b01};
    ge_r   = rem_sh >= trial;
    r2     = {rdiv_q, 1'b0};
    ge_d   = r2 >= {1'b0, m_eff};
    r2m    = r2 - {1'b0, m_eff};
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    v_d     = v_q;
    acc_d   = acc_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    rdiv_d  = rdiv_q;
    quo_d   = quo_q;
    n_d     = n_q;
    score_d = score_q;
    unique case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          v_d     = voice_i;
          acc_d   = '0;
          cnt_d   = '0;
          n_d     = '0;
          state_d = voice_i.spatial ? SC_SQ : SC_FIN;
        end
      end
      SC_SQ: begin
        acc_d = acc_q + 34'(sq);
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd2) begin
          rad_d   = acc_q + 34'(sq);
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = SC_ROOT;
        end
      end
      SC_ROOT: begin
        rem_d  = ge_r ? rem_sh - trial : rem_sh;
        root_d = {root_q[15:0], ge_r};
        rad_d  = {rad_q[31:0], 2'b00};
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          cnt_d   = '0;
          state_d = SC_DIV;
        end
      end
      SC_DIV: begin
        if (cnt_q == 5'd0) begin
          if (root_q >= {1'b0, m_eff}) begin
            n_d     = 17'h10000;
            state_d = SC_FIN;
          end else begin
            rdiv_d = root_q[15:0];
            quo_d  = '0;
            cnt_d  = 5'd1;
          end
        end else begin
          rdiv_d = ge_d ? r2m[15:0] : r2[15:0];
          quo_d  = {quo_q[14:0], ge_d};
          cnt_d  = cnt_q + 5'd1;
          if (cnt_q == 5'd16) begin
            n_d     = {1'b0, quo_q[14:0], ge_d};
            state_d = SC_FIN;
          end
        end
      end
      SC_FIN: begin
        if (v_q.spatial) begin
          score_d = {v_q.prio, 1'b1, 16'd0} - {8'd0, n_q};
        end else begin
          score_d = {9'({1'b0, v_q.prio} + 9'd1), 16'd0};
        end
        done_d  = 1'b1;
        state_d = SC_IDLE;
      end
      default: state_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    acc_q   <= acc_d;
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    rdiv_q  <= rdiv_d;
    quo_q   <= quo_d;
    n_q     <= n_d;
    score_q <= score_d;
  end

  assign done_o  = done_q;
  assign score_o = score_q;

endmodule

@@ rtl/core/voice_slot_allocator_with_stealing_core.sv @@
// Top level of the voice slot allocator: ring of slot cells, scan sequencer, score unit.
//
//  channel  | direction | handshake                 | contents
//  s_axis   | in        | tvalid/tready             | request item, operation in tuser
//  m_axis   | out       | tvalid/tready             | result item
//  cfg      | in        | cfg_we_i                  | listener position registers
//
// Release and check make one full turn of the slot ring. Allocate scores the new voice,
// then turns the ring once to scan and once to write; while no free slot has been found,
// every active, non-persistent slot scanned is scored too, in the score unit.
// Reset clears all slots to inactive with generation one. A stalled result waits in
// the output register while the next item is taken.
`timescale 1ns / 1ps
module voice_slot_allocator_with_stealing_core #(
  parameter int unsigned VOICES   = vsa_pkg::VOICES_DEF,
  parameter int unsigned GEN_BITS = vsa_pkg::GEN_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // handle_slot, handle_generation, priority_req, is_spatial, persistent,
  // pos_x, pos_y, pos_z, audible_range
  input  logic [87:0] s_axis_tdata_i,
  // operation
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status, slot, generation, active_count
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned KW   = $clog2(VOICES);
  localparam int unsigned CNTW = $clog2(VOICES + 1);
  localparam int unsigned CMPW = (KW > 5) ? KW : 5;
  localparam int unsigned GCW  = (GEN_BITS > 8) ? GEN_BITS : 8;
  localparam int unsigned SW   = vsa_pkg::SCORE_W;

  typedef enum logic [6:0] {
    T_IDLE   = 7'b0000001,
    T_NEWSC  = 7'b0000010,
    T_SCAN   = 7'b0000100,
    T_SCORE  = 7'b0001000,
    T_DECIDE = 7'b0010000,
    T_WRITE  = 7'b0100000,
    T_DONE   = 7'b1000000
  } top_state_e;

  top_state_e state_q, state_d;

  vsa_pkg::entry_t     ent_w [VOICES];
  logic [GEN_BITS-1:0] gen_w [VOICES];
  vsa_pkg::entry_t     wb_ent;
  logic [GEN_BITS-1:0] wb_gen;
  logic                shift;

  logic signed [15:0] lis_x_q, lis_y_q, lis_z_q;

  logic [1:0]      op_q, op_d;
  logic [4:0]      hs_q, hs_d;
  logic [7:0]      hg_q, hg_d;
  logic            pers_q, pers_d;
  vsa_pkg::voice_t nv_q, nv_d;
  logic [KW-1:0]   k_q, k_d;
  logic            issued_q, issued_d;
  logic [SW-1:0]   new_score_q, new_score_d;
  logic [SW-1:0]   low_q, low_d;
  logic            li_found_q, li_found_d;
  logic [KW-1:0]   li_q, li_d;
  logic            free_found_q, free_found_d;
  logic [KW-1:0]   free_q, free_d;
  logic [KW-1:0]   chosen_q, chosen_d;
  logic            do_write_q, do_write_d;
  vsa_pkg::status_e status_q, status_d;
  logic [4:0]      slot_q, slot_d;
  logic [7:0]      gen_out_q, gen_out_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            m_valid_q, m_valid_d;
  logic [23:0]     m_data_q, m_data_d;

  logic            sc_start, sc_done;
  vsa_pkg::voice_t sc_voice;
  logic [SW-1:0]   sc_score;

  vsa_pkg::entry_t     head;
  logic [GEN_BITS-1:0] head_gen, gen_bump;
  logic                k_last, hs_match, handle_ok, scan_adv;
  logic                in_acc;

  for (genvar i = 0; i < VOICES; i++) begin : g_ring
    vsa_cell #(.GEN_BITS(GEN_BITS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .ent_i   ((i == VOICES - 1) ? wb_ent : ent_w[(i + 1) % VOICES]),
      .gen_i   ((i == VOICES - 1) ? wb_gen : gen_w[(i + 1) % VOICES]),
      .ent_o   (ent_w[i]),
      .gen_o   (gen_w[i])
    );
  end

  vsa_score u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sc_start),
    .voice_i (sc_voice),
    .lis_x_i (lis_x_q),
    .lis_y_i (lis_y_q),
    .lis_z_i (lis_z_q),
    .done_o  (sc_done),
    .score_o (sc_score)
  );

  assign head     = ent_w[0];
  assign head_gen = gen_w[0];
  assign k_last   = (k_q == KW'(VOICES - 1));
  assign hs_match = (CMPW'(k_q) == CMPW'(hs_q));
  assign handle_ok = (hg_q != 8'd0) && (GCW'(head_gen) == GCW'(hg_q)) && head.active;
  assign sc_voice = (state_q == T_NEWSC) ? nv_q : head.voice;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == T_IDLE);

  always_comb begin
    gen_bump = head_gen + GEN_BITS'(1);
    if (gen_bump == '0) begin
      gen_bump = GEN_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lis_x_q <= '0;
      lis_y_q <= '0;
      lis_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        vsa_pkg::CFG_LISTENER_X: lis_x_q <= cfg_wdata_i;
        vsa_pkg::CFG_LISTENER_Y: lis_y_q <= cfg_wdata_i;
        vsa_pkg::CFG_LISTENER_Z: lis_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    hs_d         = hs_q;
    hg_d         = hg_q;
    pers_d       = pers_q;
    nv_d         = nv_q;
    k_d          = k_q;
    issued_d     = issued_q;
    new_score_d  = new_score_q;
    low_d        = low_q;
    li_found_d   = li_found_q;
    li_d         = li_q;
    free_found_d = free_found_q;
    free_d       = free_q;
    chosen_d     = chosen_q;
    do_write_d   = do_write_q;
    status_d     = status_q;
    slot_d       = slot_q;
    gen_out_d    = gen_out_q;
    count_d      = count_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    sc_start     = 1'b0;
    shift        = 1'b0;
    scan_adv     = 1'b0;
    wb_ent       = head;
    wb_gen       = head_gen;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          op_d         = s_axis_tuser_i;
          hs_d         = s_axis_tdata_i[4:0];
          hg_d         = s_axis_tdata_i[12:5];
          nv_d.prio    = s_axis_tdata_i[20:13];
          nv_d.spatial = s_axis_tdata_i[21];
          pers_d       = s_axis_tdata_i[22];
          nv_d.px      = s_axis_tdata_i[38:23];
          nv_d.py      = s_axis_tdata_i[54:39];
          nv_d.pz      = s_axis_tdata_i[70:55];
          nv_d.reach   = s_axis_tdata_i[86:71];
          k_d          = '0;
          issued_d     = 1'b0;
          li_found_d   = 1'b0;
          free_found_d = 1'b0;
          do_write_d   = 1'b0;
          count_d      = '0;
          slot_d       = s_axis_tdata_i[4:0];
          gen_out_d    = '0;
          if (s_axis_tuser_i == vsa_pkg::OP_ALLOC) begin
            status_d = vsa_pkg::ST_FREE;
            state_d  = T_NEWSC;
          end else if (s_axis_tuser_i == vsa_pkg::OP_RELEASE) begin
            status_d = vsa_pkg::ST_IGNORED;
            state_d  = T_WRITE;
          end else begin
            status_d = vsa_pkg::ST_INVALID;
            state_d  = T_WRITE;
          end
        end
      end
      T_NEWSC: begin
        sc_start = !issued_q;
        issued_d = 1'b1;
        if (sc_done) begin
          new_score_d = sc_score;
          state_d     = T_SCAN;
        end
      end
      T_SCAN: begin
        if (!head.active) begin
          if (!free_found_q) begin
            free_found_d = 1'b1;
            free_d       = k_q;
          end
          scan_adv = 1'b1;
        end else if (free_found_q || head.persistent) begin
          scan_adv = 1'b1;
        end else begin
          sc_start = 1'b1;
          state_d  = T_SCORE;
        end
      end
      T_SCORE: begin
        if (sc_done) begin
          if (!li_found_q || sc_score < low_q) begin
            li_found_d = 1'b1;
            low_d      = sc_score;
            li_d       = k_q;
          end
          scan_adv = 1'b1;
          state_d  = T_SCAN;
        end
      end
      T_DECIDE: begin
        if (free_found_q) begin
          chosen_d   = free_q;
          do_write_d = 1'b1;
          status_d   = vsa_pkg::ST_FREE;
        end else if (li_found_q && new_score_q > low_q) begin
          chosen_d   = li_q;
          do_write_d = 1'b1;
          status_d   = vsa_pkg::ST_STOLE;
        end else begin
          do_write_d = 1'b0;
          status_d   = vsa_pkg::ST_REJECT;
          slot_d     = '0;
          gen_out_d  = '0;
        end
        state_d = T_WRITE;
      end
      T_WRITE: begin
        shift = 1'b1;
        if (op_q == vsa_pkg::OP_ALLOC) begin
          if (do_write_q && k_q == chosen_q) begin
            wb_ent.active     = 1'b1;
            wb_ent.persistent = pers_q;
            wb_ent.voice      = nv_q;
            slot_d            = 5'(k_q);
            gen_out_d         = 8'(GCW'(head_gen));
          end
        end else if (op_q == vsa_pkg::OP_RELEASE) begin
          if (hs_match && handle_ok) begin
            wb_ent   = '0;
            wb_gen   = gen_bump;
            status_d = vsa_pkg::ST_RELEASED;
          end
        end else if (hs_match) begin
          status_d = handle_ok ? vsa_pkg::ST_VALID : vsa_pkg::ST_INVALID;
        end
        count_d = count_q + CNTW'(wb_ent.active);
        k_d     = k_last ? '0 : k_q + KW'(1);
        if (k_last) begin
          state_d = T_DONE;
        end
      end
      T_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {2'b00, 6'(count_q), gen_out_q, slot_q, status_q};
          state_d   = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase

    if (scan_adv) begin
      shift = 1'b1;
      k_d   = k_last ? '0 : k_q + KW'(1);
      if (k_last) begin
        state_d = T_DECIDE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      k_q       <= '0;
      issued_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      issued_q  <= issued_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    hs_q         <= hs_d;
    hg_q         <= hg_d;
    pers_q       <= pers_d;
    nv_q         <= nv_d;
    new_score_q  <= new_score_d;
    low_q        <= low_d;
    li_found_q   <= li_found_d;
    li_q         <= li_d;
    free_found_q <= free_found_d;
    free_q       <= free_d;
    chosen_q     <= chosen_d;
    do_write_q   <= do_write_d;
    status_q     <= status_d;
    slot_q       <= slot_d;
    gen_out_q    <= gen_out_d;
    count_q      <= count_d;
    m_data_q     <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_score_when_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_done |-> (state_q == T_SCORE || state_q == T_NEWSC))
    else $error("score unit finished outside a wait");

  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_DONE || state_q == T_IDLE) |-> (k_q == '0))
    else $error("slot ring not back in place");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_DONE) |-> (count_q <= CNTW'(VOICES)))
    else $error("active count beyond pool");

endmodule
